### src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes of the binary min-heap queue: controller states,
// result status codes and the command and status groups that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Key reported as removed on an insert or a failed remove
    localparam logic signed [31:0] NO_KEY = -32'sd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_CHECK,
        S_UP_CMP,
        S_DOWN_LAST,
        S_DOWN_CHECK,
        S_DOWN_LEFT,
        S_DOWN_RIGHT,
        S_FINISH
    } state_t;

    // Read address selection
    typedef enum logic [1:0] {
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    // Candidate the moving key is compared against
    typedef enum logic [1:0] {
        CAND_PARENT,
        CAND_ONE,
        CAND_PAIR
    } cand_sel_t;

    typedef struct packed {
        logic      load_in;
        logic      start_ins;
        logic      start_rem;
        logic      set_full;
        logic      set_empty;
        logic      take_last;
        logic      latch_left;
        logic      place;
        logic      step;
        logic      load_out;
        rd_sel_t   rd_sel;
        cand_sel_t cand_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
        logic one_left;
        logic pos_zero;
        logic no_left;
        logic has_right;
        logic stop;
    } dp_stat_t;

endpackage

### src/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Controller of the heap queue: sequences dispatch, sift-up and sift-down
// steps and owns both handshakes.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  bmhq_pkg::dp_stat_t   stat,
    output bmhq_pkg::ctrl_cmd_t  cmd
);

    bmhq_pkg::state_t state_reg;
    bmhq_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmhq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bmhq_pkg::S_DISPATCH;
                end
            end
            bmhq_pkg::S_DISPATCH:
            begin
                if (!stat.is_remove)
                begin
                    state_next = stat.full ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CHECK;
                end
                else if (stat.empty || stat.one_left)
                begin
                    state_next = bmhq_pkg::S_FINISH;
                end
                else
                begin
                    state_next = bmhq_pkg::S_DOWN_LAST;
                end
            end
            bmhq_pkg::S_UP_CHECK:
            begin
                state_next = stat.pos_zero ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CMP;
            end
            bmhq_pkg::S_UP_CMP:
            begin
                state_next = stat.stop ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CHECK;
            end
            bmhq_pkg::S_DOWN_LAST:
            begin
                state_next = bmhq_pkg::S_DOWN_CHECK;
            end
            bmhq_pkg::S_DOWN_CHECK:
            begin
                state_next = stat.no_left ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DOWN_LEFT;
            end
            bmhq_pkg::S_DOWN_LEFT:
            begin
                if (stat.has_right)
                begin
                    state_next = bmhq_pkg::S_DOWN_RIGHT;
                end
                else
                begin
                    state_next = stat.stop ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DOWN_CHECK;
                end
            end
            bmhq_pkg::S_DOWN_RIGHT:
            begin
                state_next = stat.stop ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DOWN_CHECK;
            end
            bmhq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bmhq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = bmhq_pkg::RD_PARENT;
        cmd.cand_sel = bmhq_pkg::CAND_PARENT;
        in_stall     = 1'b1;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            bmhq_pkg::S_DISPATCH:
            begin
                if (!stat.is_remove)
                begin
                    cmd.set_full  = stat.full;
                    cmd.start_ins = !stat.full;
                end
                else
                begin
                    cmd.set_empty = stat.empty;
                    cmd.start_rem = !stat.empty;
                    cmd.rd_sel    = bmhq_pkg::RD_LAST;
                end
            end
            bmhq_pkg::S_UP_CHECK:
            begin
                cmd.place  = stat.pos_zero;
                cmd.rd_sel = bmhq_pkg::RD_PARENT;
            end
            bmhq_pkg::S_UP_CMP:
            begin
                cmd.step     = 1'b1;
                cmd.cand_sel = bmhq_pkg::CAND_PARENT;
            end
            bmhq_pkg::S_DOWN_LAST:
            begin
                cmd.take_last = 1'b1;
            end
            bmhq_pkg::S_DOWN_CHECK:
            begin
                cmd.place  = stat.no_left;
                cmd.rd_sel = bmhq_pkg::RD_LEFT;
            end
            bmhq_pkg::S_DOWN_LEFT:
            begin
                cmd.latch_left = 1'b1;
                cmd.rd_sel     = bmhq_pkg::RD_RIGHT;
                cmd.step       = !stat.has_right;
                cmd.cand_sel   = bmhq_pkg::CAND_ONE;
            end
            bmhq_pkg::S_DOWN_RIGHT:
            begin
                cmd.step     = 1'b1;
                cmd.cand_sel = bmhq_pkg::CAND_PAIR;
            end
            bmhq_pkg::S_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### src/bmhq_dp.sv
// ----------------------------------------------------------------------------
// bmhq_dp
// Datapath of the heap queue: key store, fill count, root copy, moving key,
// hole position, compare logic and the result register.
// ----------------------------------------------------------------------------
module bmhq_dp #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmhq_pkg::ctrl_cmd_t        cmd,
    output bmhq_pkg::dp_stat_t         stat,
    input  logic                       mode,
    input  logic signed [31:0]         key,
    output logic [1:0]                 status,
    output logic signed [31:0]         removed_key,
    output logic signed [31:0]         min_key,
    output logic [6:0]                 count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;

    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic signed [31:0]   root_reg;
    logic signed [31:0]   key_reg;
    logic signed [31:0]   child_reg;
    logic [AW-1:0]        pos_reg;
    logic                 mode_reg;
    logic [1:0]           res_status_reg;
    logic signed [31:0]   removed_reg;
    logic [1:0]           out_status_reg;
    logic signed [31:0]   out_removed_reg;
    logic signed [31:0]   out_min_reg;
    logic [6:0]           out_count_reg;

    logic [IW-1:0]        left_idx;
    logic [IW-1:0]        right_idx;
    logic [IW-1:0]        cnt_ext;
    logic [AW-1:0]        parent_idx;
    logic [CW-1:0]        cnt_minus;
    logic signed [31:0]   rd_key;
    logic [31:0]          ram_rdata;
    logic signed [31:0]   cand_val;
    logic [AW-1:0]        cand_idx;
    logic                 key_less;
    logic                 stop;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic signed [31:0]   ram_wdata;

    bmhq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key     = $signed(ram_rdata);
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign cnt_ext    = IW'(cnt_reg);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign cnt_minus  = cnt_reg - CW'(1);

    // Pick the key the moving key is tested against
    always_comb
    begin
        case (cmd.cand_sel)
            bmhq_pkg::CAND_PARENT:
            begin
                cand_val = rd_key;
                cand_idx = parent_idx;
            end
            bmhq_pkg::CAND_ONE:
            begin
                cand_val = rd_key;
                cand_idx = left_idx[AW-1:0];
            end
            bmhq_pkg::CAND_PAIR:
            begin
                // Take the right child on a tie
                if (child_reg < rd_key)
                begin
                    cand_val = child_reg;
                    cand_idx = left_idx[AW-1:0];
                end
                else
                begin
                    cand_val = rd_key;
                    cand_idx = right_idx[AW-1:0];
                end
            end
            default:
            begin
                cand_val = rd_key;
                cand_idx = parent_idx;
            end
        endcase
    end

    assign key_less = key_reg < cand_val;
    assign stop     = (cmd.cand_sel == bmhq_pkg::CAND_PARENT) ? !key_less : key_less;

    always_comb
    begin
        case (cmd.rd_sel)
            bmhq_pkg::RD_LAST:   ram_raddr = cnt_minus[AW-1:0];
            bmhq_pkg::RD_PARENT: ram_raddr = parent_idx;
            bmhq_pkg::RD_LEFT:   ram_raddr = left_idx[AW-1:0];
            bmhq_pkg::RD_RIGHT:  ram_raddr = right_idx[AW-1:0];
            default:             ram_raddr = parent_idx;
        endcase
    end

    // Write the moving key when it settles, else move the candidate into the hole
    assign ram_we    = cmd.place || cmd.step;
    assign ram_wdata = (cmd.place || stop) ? key_reg : cand_val;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start_ins)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.start_rem)
        begin
            cnt_next = cnt_minus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we && (pos_reg == '0))
        begin
            root_reg <= ram_wdata;
        end
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            key_reg  <= key;
        end
        if (cmd.start_ins)
        begin
            pos_reg        <= cnt_reg[AW-1:0];
            res_status_reg <= bmhq_pkg::ST_OK;
            removed_reg    <= bmhq_pkg::NO_KEY;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= bmhq_pkg::ST_FULL;
            removed_reg    <= bmhq_pkg::NO_KEY;
        end
        if (cmd.set_empty)
        begin
            res_status_reg <= bmhq_pkg::ST_EMPTY;
            removed_reg    <= bmhq_pkg::NO_KEY;
        end
        if (cmd.start_rem)
        begin
            res_status_reg <= bmhq_pkg::ST_OK;
            removed_reg    <= root_reg;
        end
        if (cmd.take_last)
        begin
            key_reg <= rd_key;
            pos_reg <= '0;
        end
        if (cmd.latch_left)
        begin
            child_reg <= rd_key;
        end
        if (cmd.step && !stop)
        begin
            pos_reg <= cand_idx;
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_removed_reg <= removed_reg;
            out_min_reg     <= (cnt_reg != '0) ? root_reg : 32'sd0;
            out_count_reg   <= 7'(cnt_reg);
        end
    end

    assign stat.is_remove = mode_reg;
    assign stat.full      = (cnt_reg == CW'(DEPTH));
    assign stat.empty     = (cnt_reg == '0);
    assign stat.one_left  = (cnt_reg == CW'(1));
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.no_left   = (left_idx >= cnt_ext);
    assign stat.has_right = (right_idx < cnt_ext);
    assign stat.stop      = stop;

    assign status      = out_status_reg;
    assign removed_key = out_removed_reg;
    assign min_key     = out_min_reg;
    assign count       = out_count_reg;

endmodule

### src/binary_min_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Binary min-heap priority queue of signed 32-bit keys, one insert or one
// remove-minimum per request, with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, mode, key): mode 0 inserts key,
//   mode 1 removes the minimum. The block takes one request at a time and
//   holds in_stall high while a request is in work.
//   Output channel (out_valid / out_stall, status, removed_key, min_key,
//   count): one result per request, held in an output register, so the next
//   request is taken while a result still waits for the receiver.
//   A dropped insert, a failed remove and the remove of the last key go
//   from dispatch straight to finish. An insert climbs one level per parent
//   read and compare; a remove first moves the last key to the root, then
//   visits one level per read of the left child and, if present, the right
//   child. After finish the controller returns to idle, where it takes the
//   next request. The key store has one read port with a registered read.
//   Reset empties the queue at once (fill count to zero); the key store is
//   not cleared, as entries at or beyond the count are never used.
//   When the receiver stalls, the finished result holds and the request
//   behind it waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] removed_key,
    output logic signed [31:0] min_key,
    output logic [6:0]         count
);

    // Commands from the controller, status back from the datapath
    bmhq_pkg::ctrl_cmd_t cmd;
    bmhq_pkg::dp_stat_t  stat;

    // Controller: handshakes and the sift sequence
    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: key store, fill count, compare and the result register
    bmhq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .mode        (mode),
        .key         (key),
        .status      (status),
        .removed_key (removed_key),
        .min_key     (min_key),
        .count       (count)
    );

endmodule

### tb/binary_min_heap_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_tb
// Self-checking bench for the min-heap queue core. A scoreboard class keeps
// its own heap of signed keys, works out the result of every accepted request
// and compares each result the core hands out, field by field, in order.
// Stimulus is a short directed opening followed by random fill, drain and
// mixed episodes, with random gaps on the request side and random stalls on
// the result side.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_core_tb;

    localparam int HEAP_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 1150;
    // Margin beyond the longest request in work.
    localparam int SETTLE_CYCLES = 60;

    // Request codes carried on the mode field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] removed_key;
        logic signed [31:0] min_key;
        logic [6:0]         count;
    } heap_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: private heap image plus the list of results still owed.
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        logic signed [31:0] heap_keys [HEAP_DEPTH];
        int                 held;
        heap_result_t       owed_results [$];
        int                 errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void swap_keys(int a, int b);
            logic signed [31:0] t;
            t            = heap_keys[a];
            heap_keys[a] = heap_keys[b];
            heap_keys[b] = t;
        endfunction

        // Apply one accepted request to the heap image and queue its result.
        function void note_request(logic op, logic signed [31:0] k);
            heap_result_t r;
            int           pos;
            int           parent;
            int           left;
            int           right;
            int           pick;
            r.status      = bmhq_pkg::ST_OK;
            r.removed_key = bmhq_pkg::NO_KEY;
            if (op == OP_INSERT)
            begin
                if (held >= HEAP_DEPTH)
                begin
                    r.status = bmhq_pkg::ST_FULL;
                end
                else
                begin
                    heap_keys[held] = k;
                    pos = held;
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (!(heap_keys[pos] < heap_keys[parent]))
                            break;
                        swap_keys(pos, parent);
                        pos = parent;
                    end
                    held++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.status = bmhq_pkg::ST_EMPTY;
                end
                else
                begin
                    r.removed_key = heap_keys[0];
                    held--;
                    heap_keys[0] = heap_keys[held];
                    pos = 0;
                    forever
                    begin
                        left  = 2 * pos + 1;
                        right = left + 1;
                        if (left >= held)
                            break;
                        // Equal children send the key to the right.
                        if (right >= held || heap_keys[left] < heap_keys[right])
                            pick = left;
                        else
                            pick = right;
                        if (heap_keys[pos] < heap_keys[pick])
                            break;
                        swap_keys(pos, pick);
                        pos = pick;
                    end
                end
            end
            r.min_key = (held > 0) ? heap_keys[0] : 32'sd0;
            r.count   = held[6:0];
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [31:0] rk,
                                   logic signed [31:0] mk, logic [6:0] cnt);
            heap_result_t e;
            if (owed_results.size() == 0)
            begin
                $error("result with nothing owed: status %0d removed_key %0d",
                       st, rk);
                errors++;
                return;
            end
            e = owed_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (rk !== e.removed_key)
            begin
                $error("removed_key: expected %0d, got %0d", e.removed_key, rk);
                errors++;
            end
            if (mk !== e.min_key)
            begin
                $error("min_key: expected %0d, got %0d", e.min_key, mk);
                errors++;
            end
            if (cnt !== e.count)
            begin
                $error("count: expected %0d, got %0d", e.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic signed [31:0] key;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] removed_key;
    logic signed [31:0] min_key;
    logic [6:0]         count;

    heap_scoreboard board = new();

    // Quiet stretches: no request gaps and no result stalls.
    bit quiet;
    int stall_left;
    int flow_left;

    // Requests taken so far, counted at the input handshake.
    int taken_requests = 0;

    binary_min_heap_queue_core #(
        .DEPTH(HEAP_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .removed_key (removed_key),
        .min_key     (min_key),
        .count       (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #20_000_000;
        $display("binary_min_heap_queue_core_tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            taken_requests++;
    end

    // Gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Keys: full-range values, tight clusters that force ties, and extremes.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default:    return int'($urandom_range(0, 2000)) - 1000;
        endcase
    endfunction

    // Present one request, hold it until the core takes it, then log it.
    task automatic send_request(input logic op, input logic signed [31:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        key      <= k;
        forever
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
                break;
        end
        board.note_request(op, k);
    endtask

    // Fill toward full and push a few inserts past it.
    task automatic fill_episode();
        int extra;
        extra = $urandom_range(1, 3);
        while (extra > 0)
        begin
            if (board.held == HEAP_DEPTH)
                extra--;
            if ($urandom_range(0, 99) < 85)
                send_request(OP_INSERT, pick_key());
            else
                send_request(OP_REMOVE, $urandom);
        end
    endtask

    // Drain toward empty and try a few removes once nothing is left.
    task automatic drain_episode();
        int extra;
        extra = $urandom_range(1, 3);
        while (extra > 0)
        begin
            if (board.held == 0)
                extra--;
            if ($urandom_range(0, 99) < 85)
                send_request(OP_REMOVE, $urandom);
            else
                send_request(OP_INSERT, pick_key());
        end
    endtask

    task automatic mixed_episode();
        int n;
        n = $urandom_range(20, 60);
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0)
                send_request(OP_INSERT, pick_key());
            else
                send_request(OP_REMOVE, $urandom);
        end
    endtask

    // Result side: check every accepted result, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(status, removed_key, min_key, count);
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            // Mostly short holds; an occasional long one backs the core up.
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            flow_left = $urandom_range(1, 12);
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = OP_INSERT;
        key        = 32'sd0;
        out_stall  = 1'b0;
        quiet      = 1'b0;
        stall_left = 0;
        flow_left  = 0;

        // Hold reset, then release it away from the clock edge.
        repeat (7) @(posedge clk);
        #5 rst_n = 1'b1;
        @(posedge clk);

        // Directed opening: remove on an empty heap, extreme keys, duplicate
        // keys so that equal children meet during sift-down, then drain past
        // empty again.
        send_request(OP_REMOVE, KEY_MAX);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, 32'sd7);
        send_request(OP_INSERT, 32'sd7);
        send_request(OP_INSERT, 32'sd7);
        send_request(OP_INSERT, 32'sd3);
        repeat (10) send_request(OP_REMOVE, KEY_MIN);

        // Random episodes; the first one fills the heap and hits full.
        quiet = 1'b0;
        fill_episode();
        while (taken_requests < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
                0:       fill_episode();
                1:       drain_episode();
                default: mixed_episode();
            endcase
        end

        // Drop valid and wait for every owed result, then let the core settle
        // so a stray extra result would still be caught.
        in_valid <= 1'b0;
        quiet = 1'b0;
        while (board.owed_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("binary_min_heap_queue_core_tb: done, clean");
        else
            $display("binary_min_heap_queue_core_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/bmhq_ctrl.sv
src/bmhq_dp.sv
src/binary_min_heap_queue_core.sv
tb/binary_min_heap_queue_core_tb.sv
